@@ rtl/ptnm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptnm_pkg - shared constants for the two-nearest palette match
// Field widths, word layout of a palette entry, scan start distance.
// ----------------------------------------------------------------------------
package ptnm_pkg;

    localparam int COLOR_W       = 8;
    localparam int INDEX_W       = 8;
    localparam int COUNT_W       = 9;
    localparam int WORD_W        = 4 * COLOR_W;
    localparam int SQ_W          = 2 * COLOR_W;
    localparam int DIST_W        = 18;
    localparam int DEFAULT_DEPTH = 256;

    // input tdata: entry_index, red, green, blue, alpha (low to high)
    localparam int IN_DATA_W  = INDEX_W + 4 * COLOR_W;
    // output tdata: best rgba, then second rgba
    localparam int OUT_DATA_W = 2 * WORD_W;

    // tuser request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // 3 * 256 * 256, above any real distance
    localparam logic [DIST_W-1:0] START_DIST = 18'd196608;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/ptnm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptnm_ram - simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptnm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/palette_two_nearest_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_two_nearest_match_core - two nearest palette colors by RGB distance
// Palette RAM of RGBA entries, loaded by stream transfers; queries scan it.
// ----------------------------------------------------------------------------
// A transfer with tuser = 0 loads one RGBA palette entry (indexes at or above
// PALETTE_DEPTH are dropped). A transfer with tuser = 1 is a query: entries
// 0 .. N-1, N = min(palette_count, PALETTE_DEPTH), are read from the single
// read port of the palette RAM one per cycle and ranked by squared RGB
// distance; the two nearest come back as one output transfer, best first.
// Ties keep the earlier entry. A query occupies the block until its result is
// registered for output; the input side is held off during that time. Slots
// that no entry filled report entry 0. Entries must be loaded before a query
// scans them. The user must write palette_count only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module palette_two_nearest_match_core
    import ptnm_pkg::*;
#(
    parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration: palette_count
    input  logic                  i_cfg_we,
    input  logic [COUNT_W-1:0]    i_cfg_wdata,

    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [39:32] alpha
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] req_type
    input  logic                  i_s_axis_tuser,

    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] best_red, [15:8] best_green, [23:16] best_blue, [31:24] best_alpha,
    // [39:32] second_red, [47:40] second_green, [55:48] second_blue,
    // [63:56] second_alpha
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state;

    logic [COUNT_W-1:0] r_palette_count;

    // ---------------------------------------------------------------- input
    logic               s_accept;
    logic               ld_accept;
    logic               q_accept;
    logic [INDEX_W-1:0] in_index;
    logic [COLOR_W-1:0] in_red, in_green, in_blue, in_alpha;
    logic               ld_in_range;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign ld_accept       = s_accept & (i_s_axis_tuser == REQ_LOAD);
    assign q_accept        = s_accept & (i_s_axis_tuser == REQ_QUERY);

    assign in_index = i_s_axis_tdata[INDEX_W-1:0];
    assign in_red   = i_s_axis_tdata[INDEX_W +: COLOR_W];
    assign in_green = i_s_axis_tdata[INDEX_W + COLOR_W +: COLOR_W];
    assign in_blue  = i_s_axis_tdata[INDEX_W + 2*COLOR_W +: COLOR_W];
    assign in_alpha = i_s_axis_tdata[INDEX_W + 3*COLOR_W +: COLOR_W];

    // loads beyond the RAM are dropped
    assign ld_in_range = (32'(in_index) < 32'(PALETTE_DEPTH));

    // scan length: min(count, depth); at least one read to fetch entry 0
    logic [LIM_W-1:0] count_ext;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] nreads;

    assign count_ext = LIM_W'(r_palette_count);
    assign limit     = (count_ext >= LIM_W'(PALETTE_DEPTH)) ?
                       CNT_W'(PALETTE_DEPTH) : count_ext[CNT_W-1:0];
    assign nreads    = (limit == '0) ? CNT_W'(1) : limit;

    // ---------------------------------------------------------------- RAM
    logic [CNT_W-1:0]  r_issue;
    logic [CNT_W-1:0]  r_limit;
    logic [CNT_W-1:0]  r_nreads;
    logic              rd_en;
    logic              rd_last;
    logic [WORD_W-1:0] rd_data;

    assign rd_en   = (r_state == ST_SCAN);
    assign rd_last = (r_issue == r_nreads - CNT_W'(1));

    ptnm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette_ram (
        .i_clk   (i_clk),
        .i_we    (ld_accept & ld_in_range),
        .i_waddr (ADDR_W'(in_index)),
        .i_wdata ({in_alpha, in_blue, in_green, in_red}),
        .i_re    (rd_en),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // ---------------------------------------------------------------- pipe
    // s1: RAM data valid; s2: squared differences registered; then ranking
    logic r_s1_vld, r_s1_first, r_s1_cmp, r_s1_last;
    logic r_s2_vld, r_s2_first, r_s2_cmp, r_s2_last;
    logic r_out_vld;

    // query color, held during the scan
    logic [COLOR_W-1:0] r_q_red, r_q_green, r_q_blue;

    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [WORD_W-1:0] r_s2_word;

    logic [COLOR_W-1:0] d_r, d_g, d_b;
    assign d_r = abs_diff(rd_data[0 +: COLOR_W], r_q_red);
    assign d_g = abs_diff(rd_data[COLOR_W +: COLOR_W], r_q_green);
    assign d_b = abs_diff(rd_data[2*COLOR_W +: COLOR_W], r_q_blue);

    logic [DIST_W-1:0] s2_dist;
    assign s2_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    // the two running slots
    logic [WORD_W-1:0] r_best_w, r_second_w;
    logic [DIST_W-1:0] r_best_d, r_second_d;

    logic out_load;
    assign out_load = (r_state == ST_FINISH) & (~r_out_vld | i_m_axis_tready);

    // control: state, counters, valid flags, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_palette_count <= COUNT_RESET;
            r_issue         <= '0;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_palette_count <= i_cfg_wdata;
            end

            r_s1_vld <= rd_en;
            r_s2_vld <= r_s1_vld;

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_issue <= '0;
                    if (q_accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_issue <= r_issue + CNT_W'(1);
                    if (rd_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_s2_vld && r_s2_last) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (q_accept) begin
            r_q_red   <= in_red;
            r_q_green <= in_green;
            r_q_blue  <= in_blue;
            r_limit   <= limit;
            r_nreads  <= nreads;
        end

        // tags travel alongside the RAM read
        r_s1_first <= (r_issue == '0);
        r_s1_cmp   <= (r_issue < r_limit);
        r_s1_last  <= rd_last;

        r_sq_r     <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g     <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b     <= SQ_W'(d_b) * SQ_W'(d_b);
        r_s2_word  <= rd_data;
        r_s2_first <= r_s1_first;
        r_s2_cmp   <= r_s1_cmp;
        r_s2_last  <= r_s1_last;

        if (r_s2_vld) begin
            if (r_s2_first) begin
                // entry 0 seeds both slots; it ranks only if counted
                r_best_w   <= r_s2_word;
                r_second_w <= r_s2_word;
                r_best_d   <= r_s2_cmp ? s2_dist : START_DIST;
                r_second_d <= START_DIST;
            end else if (r_s2_cmp) begin
                priority if (s2_dist < r_best_d) begin
                    r_second_w <= r_best_w;
                    r_second_d <= r_best_d;
                    r_best_w   <= r_s2_word;
                    r_best_d   <= s2_dist;
                end else if (s2_dist < r_second_d) begin
                    r_second_w <= r_s2_word;
                    r_second_d <= s2_dist;
                end
            end
        end

        if (out_load) begin
            o_m_axis_tdata <= {r_second_w, r_best_w};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;

endmodule

@@ tb/sv/palette_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_match_checker - scoreboard for the two-nearest palette match
// Follows request and result transfers, predicts the two nearest entries
// for every query and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module palette_match_checker
    import ptnm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_W-1:0]    i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_open_queries
);

    // packed so that red sits in the low byte, as in the palette word
    typedef struct packed {
        logic [COLOR_W-1:0] alpha;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_rgba;

    typedef struct packed {
        t_rgba second;
        t_rgba best;
    } t_nearest_pair;

    t_rgba              palette_copy [DEFAULT_DEPTH];
    logic [COUNT_W-1:0] scan_count;
    t_nearest_pair      nearest_queue [$];
    t_nearest_pair      got_pair;
    t_nearest_pair      want_pair;
    t_rgba              req_color;
    logic [INDEX_W-1:0] req_index;
    int                 result_seq;

    initial begin
        o_fail_count   = 0;
        o_open_queries = 0;
        result_seq     = 0;
        scan_count     = COUNT_RESET;
    end

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, result_seq, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic logic [DIST_W-1:0] rgb_distance(input t_rgba e, input t_rgba q);
        logic [COLOR_W-1:0] dr;
        logic [COLOR_W-1:0] dg;
        logic [COLOR_W-1:0] db;
        dr = (e.red   >= q.red)   ? e.red   - q.red   : q.red   - e.red;
        dg = (e.green >= q.green) ? e.green - q.green : q.green - e.green;
        db = (e.blue  >= q.blue)  ? e.blue  - q.blue  : q.blue  - e.blue;
        return DIST_W'(SQ_W'(dr) * SQ_W'(dr)) + DIST_W'(SQ_W'(dg) * SQ_W'(dg))
             + DIST_W'(SQ_W'(db) * SQ_W'(db));
    endfunction

    // scan in storage order; strict compare keeps the earlier entry on a tie
    function automatic t_nearest_pair find_two_nearest(input t_rgba q);
        t_nearest_pair      p;
        logic [DIST_W-1:0]  best_d;
        logic [DIST_W-1:0]  second_d;
        logic [DIST_W-1:0]  d;
        int                 limit;
        int                 i;
        limit    = (scan_count > DEFAULT_DEPTH) ? DEFAULT_DEPTH : int'(scan_count);
        p.best   = palette_copy[0];
        p.second = palette_copy[0];
        best_d   = START_DIST;
        second_d = START_DIST;
        for (i = 0; i < limit; i++) begin
            d = rgb_distance(palette_copy[i], q);
            if (d < best_d) begin
                p.second = p.best;
                second_d = best_d;
                p.best   = palette_copy[i];
                best_d   = d;
            end else if (d < second_d) begin
                p.second = palette_copy[i];
                second_d = d;
            end
        end
        return p;
    endfunction

    task automatic compare_color(input string slot, input t_rgba got, input t_rgba want);
        if (got.red !== want.red)
            report_error($sformatf("%s_red got 0x%h expected 0x%h", slot, got.red, want.red));
        if (got.green !== want.green)
            report_error($sformatf("%s_green got 0x%h expected 0x%h", slot, got.green,
                                   want.green));
        if (got.blue !== want.blue)
            report_error($sformatf("%s_blue got 0x%h expected 0x%h", slot, got.blue,
                                   want.blue));
        if (got.alpha !== want.alpha)
            report_error($sformatf("%s_alpha got 0x%h expected 0x%h", slot, got.alpha,
                                   want.alpha));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_count = COUNT_RESET;
            nearest_queue.delete();
        end else begin
            if (i_cfg_we)
                scan_count = i_cfg_wdata;
            // result side first: a result never belongs to a query taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got_pair = t_nearest_pair'(i_m_tdata);
                if (nearest_queue.size() == 0) begin
                    report_error("result transfer with no query outstanding");
                end else begin
                    want_pair = nearest_queue.pop_front();
                    compare_color("best", got_pair.best, want_pair.best);
                    compare_color("second", got_pair.second, want_pair.second);
                end
                result_seq = result_seq + 1;
            end
            if (i_s_tvalid && i_s_tready) begin
                req_index = i_s_tdata[INDEX_W-1:0];
                req_color = t_rgba'(i_s_tdata[IN_DATA_W-1:INDEX_W]);
                if (i_s_tuser == REQ_QUERY)
                    nearest_queue.push_back(find_two_nearest(req_color));
                else if (int'(req_index) < DEFAULT_DEPTH)
                    palette_copy[req_index] = req_color;
            end
            o_open_queries = nearest_queue.size();
        end
    end

endmodule

@@ tb/sv/tb_palette_two_nearest_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_two_nearest_match_core - stimulus and verdict for the match core
// Loads palette entries and sends color queries over the request stream,
// walks palette_count through its range, stalls both streams at random and
// lets the checker judge every result transfer.
// ----------------------------------------------------------------------------
module tb_palette_two_nearest_match_core;
    import ptnm_pkg::*;

    localparam int RESET_CYCLES      = 6;
    localparam int RANDOM_ITEMS      = 500;
    localparam int MAX_GAP           = 8;
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT       = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [COUNT_W-1:0]    i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    int fail_count;
    int open_queries;

    // what the stimulus has put into the palette, so queries only scan
    // entries that were written
    bit                     entry_loaded [DEFAULT_DEPTH];
    logic [3*COLOR_W-1:0]   entry_rgb    [DEFAULT_DEPTH];   // {blue, green, red}

    int scan_len      = 1;     // entries a query scans under the current count
    int items_sent    = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    bit send_burst    = 1'b0;
    bit sink_burst    = 1'b0;

    palette_two_nearest_match_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    palette_match_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_tvalid     (i_s_axis_tvalid),
        .i_s_tready     (o_s_axis_tready),
        .i_s_tdata      (i_s_axis_tdata),
        .i_s_tuser      (i_s_axis_tuser),
        .i_m_tvalid     (o_m_axis_tvalid),
        .i_m_tready     (i_m_axis_tready),
        .i_m_tdata      (o_m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_open_queries (open_queries)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d cycles, %0d queries still open", cycle_count,
                     open_queries);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One request transfer. Entered right after the previous transfer was
    // taken; tvalid stays high when no gap is drawn so back-to-back items
    // never see a low pulse.
    task automatic push_request(input logic user, input logic [INDEX_W-1:0] index,
                                input logic [COLOR_W-1:0] red,
                                input logic [COLOR_W-1:0] green,
                                input logic [COLOR_W-1:0] blue,
                                input logic [COLOR_W-1:0] alpha);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = user;
        i_s_axis_tdata  = {alpha, blue, green, red, index};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent = items_sent + 1;
    endtask

    task automatic load_entry(input logic [INDEX_W-1:0] index,
                              input logic [COLOR_W-1:0] red,
                              input logic [COLOR_W-1:0] green,
                              input logic [COLOR_W-1:0] blue,
                              input logic [COLOR_W-1:0] alpha);
        push_request(REQ_LOAD, index, red, green, blue, alpha);
        entry_loaded[index] = 1'b1;
        entry_rgb[index]    = {blue, green, red};
        loads_sent = loads_sent + 1;
    endtask

    // index and alpha are don't-care on a query; fill them with noise
    task automatic ask_nearest(input logic [COLOR_W-1:0] red,
                               input logic [COLOR_W-1:0] green,
                               input logic [COLOR_W-1:0] blue);
        push_request(REQ_QUERY, INDEX_W'($urandom), red, green, blue, COLOR_W'($urandom));
        queries_sent = queries_sent + 1;
    endtask

    // drop tvalid, wait for every outstanding result, then let the core go idle
    task automatic settle_block();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (open_queries != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_palette_count(input logic [COUNT_W-1:0] value);
        settle_block();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        scan_len    = (value > DEFAULT_DEPTH) ? DEFAULT_DEPTH : int'(value);
        settings_used = settings_used + 1;
    endtask

    // Result side: random per-transfer stalls, bursts with tready held high,
    // and two long hold-offs while the sender keeps pushing, so the core
    // backs up and deasserts its own tready.
    initial begin : result_sink
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (results_seen == 15 || results_seen == 80) begin
                i_m_axis_tready = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge i_clk);
            end else begin
                if ($urandom_range(0, 15) == 0)
                    sink_burst = !sink_burst;
                stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    i_m_axis_tready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            results_seen = results_seen + 1;
        end
    end

    initial begin : stimulus
        int                 directed_items;
        int                 phase;
        int                 pick;
        int                 window;
        int                 idx;
        int                 j;
        logic [COUNT_W-1:0] count;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser  = REQ_LOAD;
        i_s_axis_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed ----
        // count is still at its reset value of 1: a lone entry fills both slots
        load_entry(8'd0, 8'hff, 8'hff, 8'hff, 8'hff);
        ask_nearest(8'h00, 8'h00, 8'h00);           // largest possible distance
        ask_nearest(8'hff, 8'hff, 8'hff);           // exact hit
        // count of zero: nothing scanned, both slots report entry 0
        set_palette_count(9'd0);
        ask_nearest(8'h0c, 8'h22, 8'h38);
        // two entries with the same color but different alpha: tie order
        load_entry(8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        load_entry(8'd2, 8'h00, 8'h00, 8'h00, 8'h5a);
        load_entry(8'd3, 8'hff, 8'h00, 8'hff, 8'ha5);
        load_entry(8'd255, 8'h12, 8'h34, 8'h56, 8'h78);   // top index
        set_palette_count(9'd4);
        ask_nearest(8'h00, 8'h00, 8'h00);
        ask_nearest(8'hff, 8'hff, 8'hff);
        ask_nearest(8'hff, 8'h00, 8'hff);
        ask_nearest(8'h80, 8'h80, 8'h80);
        set_palette_count(9'd2);
        ask_nearest(8'h00, 8'h00, 8'h00);
        directed_items = items_sent;

        // ---- random phases: set a count, make sure the scanned window is
        // loaded, then a batch of queries, rewrites and stray loads ----
        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            case (phase)
                1: count = 9'd256;                          // full palette
                3: count = 9'd511;                          // above depth, saturates
                5: count = 9'd1;
                7: count = COUNT_W'($urandom_range(257, 510));
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        count = 9'd0;
                    else if (pick <= 2)
                        count = COUNT_W'($urandom_range(17, 64));
                    else
                        count = COUNT_W'($urandom_range(1, 16));
                end
            endcase
            set_palette_count(count);
            // entry 0 is always read, even with a count of zero
            window = (scan_len > 0) ? scan_len : 1;
            for (idx = 0; idx < window; idx++)
                if (!entry_loaded[idx])
                    load_entry(INDEX_W'(idx), COLOR_W'($urandom), COLOR_W'($urandom),
                               COLOR_W'($urandom), COLOR_W'($urandom));

            repeat ($urandom_range(4, 20)) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    pick = $urandom_range(0, 7);
                    if (pick < 2) begin
                        // exact hit on a scanned entry
                        j = $urandom_range(0, window - 1);
                        {b, g, r} = entry_rgb[j];
                    end else if (pick == 2) begin
                        // a corner of the color cube
                        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                        g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                        b = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    end else begin
                        {b, g, r} = 24'($urandom);
                    end
                    ask_nearest(r, g, b);
                end else if (pick < 17) begin
                    // rewrite inside the window, often copying another entry's
                    // color to create distance ties
                    idx = $urandom_range(0, window - 1);
                    if ($urandom_range(0, 2) == 0)
                        {b, g, r} = entry_rgb[$urandom_range(0, window - 1)];
                    else
                        {b, g, r} = 24'($urandom);
                    load_entry(INDEX_W'(idx), r, g, b, COLOR_W'($urandom));
                end else begin
                    load_entry(INDEX_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                               COLOR_W'($urandom), COLOR_W'($urandom));
                end
            end
            phase = phase + 1;
        end

        // ---- drain ----
        settle_block();

        $display("Run covered %0d loads and %0d queries across %0d palette_count writes",
                 loads_sent, queries_sent, settings_used);
        $display("Counts from 0 to 511 used; %0d results taken with random and long stalls",
                 results_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
